### hw/rtl/inverted_pwm_pair_decoder_top_defines.svh
// Assertion macros shared by the pulse-pair decoder RTL
`ifndef INVERTED_PWM_PAIR_DECODER_TOP_DEFINES_SVH
`define INVERTED_PWM_PAIR_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define IPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define IPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IPD_ASSERT(label, clk, rst_n, prop, msg)
`define IPD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### hw/rtl/ipd_pkg.sv
// Types and constants of the pulse-pair decoder
package ipd_pkg;

    localparam int CFG_TIME_W = 16;
    localparam int PCT_W      = 7;
    localparam int FRAME_W    = 7;
    localparam int PROTO_W    = 8;
    localparam int CODE_W     = 64;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam int PCT_SCALE = 100;

    localparam logic [CFG_TIME_W-1:0] SHORT_TIME_RST = 16'd375;
    localparam logic [CFG_TIME_W-1:0] LONG_TIME_RST  = 16'd1125;
    localparam logic [PCT_W-1:0]      TOL_PCT_RST    = 7'd20;
    localparam logic [FRAME_W-1:0]    FRAME_BITS_RST = 7'd18;
    localparam logic [PROTO_W-1:0]    PROTO_IDX_RST  = 8'd0;

    typedef enum logic [2:0] {
        REG_SHORT_TIME     = 3'd0,
        REG_LONG_TIME      = 3'd1,
        REG_TOL_PERCENT    = 3'd2,
        REG_FRAME_BITS     = 3'd3,
        REG_PROTOCOL_INDEX = 3'd4
    } t_reg_idx;

    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FAIL = 1'b1
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [CODE_W-1:0]    code;
        logic [FRAME_W-1:0]   bit_count;
        logic [PROTO_W-1:0]   protocol;
    } t_result;

endpackage

### hw/rtl/ipd_channels.sv
// Valid/ready channels of the pulse-pair decoder: input pairs and results
interface ipd_pair_if #(
    parameter int TIME_BITS = 16
) ();
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] low_time;
    logic [TIME_BITS-1:0] high_time;
    logic                 first;
    logic                 last;

    modport source (output valid, low_time, high_time, first, last, input ready);
    modport sink   (input valid, low_time, high_time, first, last, output ready);
endinterface

interface ipd_result_if
    import ipd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               status;
    logic [CODE_W-1:0]  code;
    logic [FRAME_W-1:0] bit_count;
    logic [PROTO_W-1:0] protocol;

    modport source (output valid, status, code, bit_count, protocol, input ready);
    modport sink   (input valid, status, code, bit_count, protocol, output ready);
endinterface

### hw/rtl/inverted_pwm_pair_decoder_top.sv
// Pulse-pair decoder top level: APB registers, pair register, decode and result register
//
// Decodes (low, high) pulse-duration pairs into bits: long low with short high is 0, short
// low with long high is 1, each within tolerance_percent of nominal. Bits shift in MSB
// first; once frame_bits have been gathered one success transaction carries the code, the
// count and protocol_index. A mismatch, or a last pair before the frame is full, gives one
// failure transaction; further pairs are dropped until one flagged first. The block takes
// one pair per clock while the result channel does not stall. A pair waits in the pair
// register, where the single decode stage works, and its result then goes to the result
// register. Both channels may stall freely. Tolerance products are registered from the
// configuration, so a register write takes effect on pairs accepted from the next clock on.
`include "inverted_pwm_pair_decoder_top_defines.svh"

module inverted_pwm_pair_decoder_top
    import ipd_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    ipd_pair_if.sink              i_pair,
    ipd_result_if.source          o_result
);

    // nominal times lose their upper bits when the timer is narrower than the register
    localparam int CFG_W  = (TIME_BITS < CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
    localparam int PROD_W = CFG_W + PCT_W;
    localparam int GAP_W  = TIME_BITS + 8;

    // configuration
    logic [CFG_TIME_W-1:0] r_short_time;
    logic [CFG_TIME_W-1:0] r_long_time;
    logic [PCT_W-1:0]      r_tol_pct;
    logic [FRAME_W-1:0]    r_frame_bits;
    logic [PROTO_W-1:0]    r_proto_idx;
    t_reg_idx              w_reg_idx;
    logic                  w_cfg_wr;

    // tolerance products, nominal * percent
    logic [PROD_W-1:0]     r_prod_s;
    logic [PROD_W-1:0]     r_prod_l;
    logic [TIME_BITS-1:0]  w_st;
    logic [TIME_BITS-1:0]  w_lt;

    // pair register
    logic                  r_in_valid;
    logic [TIME_BITS-1:0]  r_lo;
    logic [TIME_BITS-1:0]  r_hi;
    logic                  r_first;
    logic                  r_last;
    logic                  w_in_fire;
    logic                  w_fire;

    // capture state
    logic [CODE_W-1:0]     r_code;
    logic [FRAME_W-1:0]    r_cnt;
    logic                  r_open;
    logic [CODE_W-1:0]     n_code;
    logic [FRAME_W-1:0]    n_cnt;
    logic                  n_open;

    // decode
    logic                  w_is0;
    logic                  w_is1;
    logic                  w_emit;
    t_result               w_res;

    // result register
    logic                  r_out_valid;
    t_result               r_out;

    function automatic logic [TIME_BITS-1:0] f_gap(
        input logic [TIME_BITS-1:0] a,
        input logic [TIME_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // gap < floor(prod/100) is the same as 100*(gap+1) <= prod, no divider needed
    function automatic logic f_near(
        input logic [TIME_BITS-1:0] gap,
        input logic [PROD_W-1:0]    prod
    );
        logic [GAP_W-1:0] g1;
        g1 = GAP_W'(gap) + GAP_W'(1);
        return (g1 * GAP_W'(PCT_SCALE)) <= GAP_W'(prod);
    endfunction

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_time <= SHORT_TIME_RST;
            r_long_time  <= LONG_TIME_RST;
            r_tol_pct    <= TOL_PCT_RST;
            r_frame_bits <= FRAME_BITS_RST;
            r_proto_idx  <= PROTO_IDX_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_SHORT_TIME:     r_short_time <= pwdata[CFG_TIME_W-1:0];
                REG_LONG_TIME:      r_long_time  <= pwdata[CFG_TIME_W-1:0];
                REG_TOL_PERCENT:    r_tol_pct    <= pwdata[PCT_W-1:0];
                REG_FRAME_BITS:     r_frame_bits <= pwdata[FRAME_W-1:0];
                REG_PROTOCOL_INDEX: r_proto_idx  <= pwdata[PROTO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_SHORT_TIME:     prdata = APB_DATA_W'(r_short_time);
            REG_LONG_TIME:      prdata = APB_DATA_W'(r_long_time);
            REG_TOL_PERCENT:    prdata = APB_DATA_W'(r_tol_pct);
            REG_FRAME_BITS:     prdata = APB_DATA_W'(r_frame_bits);
            REG_PROTOCOL_INDEX: prdata = APB_DATA_W'(r_proto_idx);
            default:            prdata = '0;
        endcase
    end

    // ---------------- tolerance ----------------
    assign w_st = TIME_BITS'(r_short_time[CFG_W-1:0]);
    assign w_lt = TIME_BITS'(r_long_time[CFG_W-1:0]);

    always_ff @(posedge i_clk) begin
        r_prod_s <= PROD_W'(r_short_time[CFG_W-1:0]) * PROD_W'(r_tol_pct);
        r_prod_l <= PROD_W'(r_long_time[CFG_W-1:0]) * PROD_W'(r_tol_pct);
    end

    // ---------------- pair register ----------------
    assign w_fire       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_pair.ready = !r_in_valid || w_fire;
    assign w_in_fire    = i_pair.valid && i_pair.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_lo    <= i_pair.low_time;
            r_hi    <= i_pair.high_time;
            r_first <= i_pair.first;
            r_last  <= i_pair.last;
        end
    end

    // ---------------- decode ----------------
    assign w_is0 = f_near(f_gap(r_lo, w_lt), r_prod_l) && f_near(f_gap(r_hi, w_st), r_prod_s);
    assign w_is1 = f_near(f_gap(r_lo, w_st), r_prod_s) && f_near(f_gap(r_hi, w_lt), r_prod_l);

    always_comb begin
        logic [CODE_W-1:0]  c0;
        logic [FRAME_W-1:0] k0;
        logic [CODE_W-1:0]  c1;
        logic [FRAME_W-1:0] k1;
        logic               o0;

        c0 = r_first ? '0 : r_code;
        k0 = r_first ? '0 : r_cnt;
        o0 = r_first || r_open;
        c1 = {c0[CODE_W-2:0], !w_is0};
        k1 = k0 + FRAME_W'(1);

        w_emit = 1'b0;
        w_res  = '{status: STATUS_FAIL, code: '0, bit_count: '0, protocol: '0};
        n_code = c0;
        n_cnt  = k0;
        n_open = o0;

        if (o0) begin
            if (k0 >= r_frame_bits) begin
                // frame already full (frame_bits zero or lowered): report, pair unused
                w_emit = 1'b1;
                w_res  = '{status: STATUS_OK, code: c0, bit_count: k0, protocol: r_proto_idx};
                n_open = 1'b0;
            end else if (!w_is0 && !w_is1) begin
                w_emit = 1'b1;
                n_open = 1'b0;
            end else begin
                n_code = c1;
                n_cnt  = k1;
                if (k1 >= r_frame_bits) begin
                    w_emit = 1'b1;
                    w_res  = '{status: STATUS_OK, code: c1, bit_count: k1,
                               protocol: r_proto_idx};
                    n_open = 1'b0;
                end else if (r_last) begin
                    w_emit = 1'b1;
                    n_open = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_cnt  <= '0;
        end else if (w_fire) begin
            r_open <= n_open;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_code <= n_code;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.status    = r_out.status;
    assign o_result.code      = r_out.code;
    assign o_result.bit_count = r_out.bit_count;
    assign o_result.protocol  = r_out.protocol;

    // ---------------- assertions ----------------
    `IPD_ASSERT(a_fail_fields_zero, i_clk, i_rst_n, (r_out_valid && r_out.status == STATUS_FAIL) |-> (r_out.code == '0 && r_out.bit_count == '0 && r_out.protocol == '0), "failure transaction with non-zero fields")
    `IPD_ASSERT(a_ok_count_full, i_clk, i_rst_n, (r_out_valid && r_out.status == STATUS_OK) |-> (r_out.bit_count >= r_frame_bits), "success transaction before frame complete")
    `IPD_ASSERT(a_emit_closes, i_clk, i_rst_n, (w_fire && w_emit) |=> !r_open, "capture still open after a result")
    `IPD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_in_valid && !r_out_valid), "pipeline not empty after reset")

endmodule
